// ===== hdl/mme_pkg.sv =====
// Package for the matrix multiply element block: field widths, register and
// function codes, state encoding and parameter defaults. No dependencies.
package mme_pkg;

  // Parameter defaults.
  localparam int unsigned MAX_DIM_DEF       = 16;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  // Fixed field widths of the streams and of the configuration port.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 2;
  localparam int unsigned DIM_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Fraction bits of the fixed point elements.
  localparam int unsigned FRAC_BITS = 16;

  // Dimension registers come out of reset at this value.
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A = 2'd0,
    FUNC_WR_B = 2'd1,
    FUNC_RD_C = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_RES  = 4'b1000
  } state_t;

endpackage

// ===== hdl/mme_ram.sv =====
// Generic simple dual port RAM: one write port, one read port with
// registered read data. No dependencies.
module mme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/matrix_multiply_element.sv =====
// Top level of the matrix multiply element block: two element stores and one
// shared multiply-accumulate unit. Depends on mme_pkg and mme_ram.
//
// Channel   Dir  Signals                          Contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser request: func, row, col, value
// m_*       out  m_tvalid m_tready m_tdata m_tuser result: product, flags
// cfg_*     in   cfg_we cfg_index cfg_data         dimension register writes
//
// A write request or a rejected request goes to the result state and loads the
// result register once that is free. A product read first reads the stores once
// per inner index below n, n being the clamped inner dimension, through the
// single read port of each store, then a multiplier and an accumulator stage,
// then saturation. Synchronous active high reset returns the
// sequencer to idle, empties the result register and sets all dimensions to
// 16; store contents are not cleared. A stalled result register holds its
// value while the next request is already taken and worked on.
module matrix_multiply_element
  import mme_pkg::*;
#(
  parameter int unsigned MAX_DIM       = MAX_DIM_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // row [3:0], col [7:4], value [39:8]
  input  logic [FUNC_W-1:0]    s_tuser,   // func [1:0]
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // product [31:0]
  output logic [M_TUSER_W-1:0] m_tuser,   // saturated [0], bad_index [1]
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int unsigned EW      = ELEMENT_WIDTH;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(DEPTH);
  // Largest dimension that the 5 bit registers and the stores both allow.
  localparam int unsigned DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;
  // The accumulator holds up to 31 exact products and at least one integer
  // bit above the element range so that overflow is visible.
  localparam int unsigned ACC_A   = 2 * EW + DIM_W;
  localparam int unsigned ACC_B   = FRAC_BITS + EW + 1;
  localparam int unsigned ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int unsigned HI_W    = ACC_W - FRAC_BITS - EW + 1;

  localparam logic [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};

  state_t state;

  // Dimension registers and their clamped values.
  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] cols_b;
  logic [DIM_W-1:0] ra_c;
  logic [DIM_W-1:0] id_c;
  logic [DIM_W-1:0] cb_c;

  // Request fields.
  func_t             in_func;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [VALUE_W-1:0] in_value;
  logic [DIM_W-1:0]  row_x;
  logic [DIM_W-1:0]  col_x;

  logic              accept;
  logic              in_bad;
  logic              we_a;
  logic              we_b;
  logic              start_rd;
  logic [AW-1:0]     wr_addr;

  // Multiply-accumulate sequencer.
  logic [DIM_W-1:0]         k;
  logic [AW-1:0]            addr_a;
  logic [AW-1:0]            addr_b;
  logic                     issue;
  logic                     rd_vld;
  logic                     mul_vld;
  logic [EW-1:0]            rdata_a;
  logic [EW-1:0]            rdata_b;
  logic signed [2*EW-1:0]   prod;
  logic signed [ACC_W-1:0]  acc;
  logic [HI_W-1:0]          acc_hi;
  logic [EW-1:0]            acc_elem;
  logic                     sat_pos;
  logic                     sat_neg;

  // Result held between the sequencer and the output register.
  logic [VALUE_W-1:0] res_product;
  logic               res_sat;
  logic               res_bad;
  logic               out_free;

  always_comb begin
    ra_c = (rows_a    > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : rows_a;
    id_c = (inner_dim > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : inner_dim;
    cb_c = (cols_b    > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : cols_b;
  end

  assign in_func  = func_t'(s_tuser);
  assign in_row   = s_tdata[ROW_W-1:0];
  assign in_col   = s_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_value = s_tdata[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W];
  assign row_x    = DIM_W'(in_row);
  assign col_x    = DIM_W'(in_col);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign wr_addr  = AW'(int'(in_row) * MAX_DIM + int'(in_col));

  // Bounds check per function; an unused function code is neither bad nor
  // does it touch the stores.
  always_comb begin
    in_bad   = 1'b0;
    we_a     = 1'b0;
    we_b     = 1'b0;
    start_rd = 1'b0;
    unique case (in_func)
      FUNC_WR_A: begin
        in_bad = !(row_x < ra_c && col_x < id_c);
        we_a   = accept && !in_bad;
      end
      FUNC_WR_B: begin
        in_bad = !(row_x < id_c && col_x < cb_c);
        we_b   = accept && !in_bad;
      end
      FUNC_RD_C: begin
        in_bad   = !(row_x < ra_c && col_x < cb_c);
        start_rd = accept && !in_bad;
      end
      default: begin
        in_bad = 1'b0;
      end
    endcase
  end

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (in_value[EW-1:0]),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (in_value[EW-1:0]),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  // One inner index is issued per cycle while the count is below the inner
  // dimension; read data and then products follow, marked by rd_vld and mul_vld.
  assign issue = (state == ST_MAC) && (k < id_c);

  // The floored sum is the accumulator shifted right by the fraction bits;
  // it fits the element when all bits from its sign bit upward agree.
  assign acc_hi   = acc[ACC_W-1:FRAC_BITS+EW-1];
  assign acc_elem = acc[FRAC_BITS+EW-1:FRAC_BITS];
  assign sat_pos  = !acc[ACC_W-1] && (|acc_hi);
  assign sat_neg  = acc[ACC_W-1] && !(&acc_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_vld   <= 1'b0;
      mul_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld  <= issue;
      mul_vld <= rd_vld;
      // The result register is refilled in the result state when it is free, else
      // emptied when the downstream side takes its result.
      if (state == ST_RES && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_rd) begin
            state <= ST_MAC;
          end else if (accept) begin
            state <= ST_RES;
          end
        end
        ST_MAC: begin
          if (!issue && !rd_vld && !mul_vld) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      k           <= '0;
      addr_a      <= AW'(int'(in_row) * MAX_DIM);
      addr_b      <= AW'(in_col);
      acc         <= '0;
      res_product <= '0;
      res_sat     <= 1'b0;
      res_bad     <= in_bad;
    end
    if (issue) begin
      k      <= k + 1'b1;
      addr_a <= addr_a + 1'b1;
      addr_b <= addr_b + AW'(MAX_DIM);
    end
    if (rd_vld) begin
      prod <= $signed(rdata_a) * $signed(rdata_b);
    end
    if (mul_vld) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == ST_FIN) begin
      res_sat <= sat_pos || sat_neg;
      if (sat_pos) begin
        res_product <= VALUE_W'($signed(ELEM_MAX));
      end else if (sat_neg) begin
        res_product <= VALUE_W'($signed(ELEM_MIN));
      end else begin
        res_product <= VALUE_W'($signed(acc_elem));
      end
    end
    if (state == ST_RES && out_free) begin
      m_tdata <= res_product;
      m_tuser <= {res_bad, res_sat};
    end
  end

  // The issue count never runs past the inner dimension.
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC |-> k <= id_c)
    else $error("inner index count ran past the inner dimension");

  // Saturation is only taken once the multiply pipeline has drained.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> !rd_vld && !mul_vld)
    else $error("saturation started with products in flight");

  // A rejected request never carries a product or a saturation flag.
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
    else $error("bad index result carries data");

  // An in-range product read enters the accumulate phase.
  a_start_rd: assert property (@(posedge clk) disable iff (rst)
    start_rd |=> state == ST_MAC)
    else $error("product read did not start accumulation");

endmodule

// ===== sim/mme_checker.sv =====
`timescale 1ns / 100ps
// Checker for the matrix multiply element block: it watches the request, result and
// configuration channels, predicts every result and compares it. Depends on mme_pkg.
module mme_checker
  import mme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [FUNC_W-1:0]    s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [M_TUSER_W-1:0] m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int unsigned          pending,
  output int unsigned          errors
);

  localparam int unsigned CELLS = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int unsigned ACC_W = 2 * VALUE_W + 8;
  localparam logic signed [ACC_W-1:0] ELEM_MAX =
    {{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ELEM_MIN =
    {{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] product;
    logic                      saturated;
    logic                      bad_index;
  } element_result_t;

  logic [DIM_W-1:0]          rows_a_q    = DIM_RESET;
  logic [DIM_W-1:0]          inner_dim_q = DIM_RESET;
  logic [DIM_W-1:0]          cols_b_q    = DIM_RESET;
  logic signed [VALUE_W-1:0] a_mirror [CELLS];
  logic signed [VALUE_W-1:0] b_mirror [CELLS];
  element_result_t           expected_elems [$];
  element_result_t           got;
  element_result_t           want;
  int unsigned               mismatch_count = 0;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEF) ? DIM_W'(MAX_DIM_DEF) : d;
  endfunction

  // Applies one request to the mirrored stores and returns the result it causes.
  function automatic element_result_t predict_element(input logic [FUNC_W-1:0] f,
                                                      input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c,
                                                      input logic signed [VALUE_W-1:0] v);
    element_result_t             res;
    logic [DIM_W-1:0]            ra;
    logic [DIM_W-1:0]            id;
    logic [DIM_W-1:0]            cb;
    logic signed [ACC_W-1:0]     acc;
    logic signed [2*VALUE_W-1:0] term;
    int                          k;
    res = '0;
    ra  = clamp_dim(rows_a_q);
    id  = clamp_dim(inner_dim_q);
    cb  = clamp_dim(cols_b_q);
    case (f)
      FUNC_WR_A: begin
        if (r < ra && c < id) a_mirror[{r, c}] = v;
        else res.bad_index = 1'b1;
      end
      FUNC_WR_B: begin
        if (r < id && c < cb) b_mirror[{r, c}] = v;
        else res.bad_index = 1'b1;
      end
      FUNC_RD_C: begin
        if (r < ra && c < cb) begin
          acc = '0;
          for (k = 0; k < id; k++) begin
            term = a_mirror[{r, 4'(k)}] * b_mirror[{4'(k), c}];
            acc  = acc + term;
          end
          // Arithmetic shift floors toward minus infinity.
          acc = acc >>> FRAC_BITS;
          if (acc > ELEM_MAX) begin
            res.product   = ELEM_MAX[VALUE_W-1:0];
            res.saturated = 1'b1;
          end else if (acc < ELEM_MIN) begin
            res.product   = ELEM_MIN[VALUE_W-1:0];
            res.saturated = 1'b1;
          end else begin
            res.product = acc[VALUE_W-1:0];
          end
        end else begin
          res.bad_index = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rows_a_q    = DIM_RESET;
      inner_dim_q = DIM_RESET;
      cols_b_q    = DIM_RESET;
      expected_elems.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.product   = m_tdata;
        got.saturated = m_tuser[0];
        got.bad_index = m_tuser[1];
        if (expected_elems.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual product %h flags %b",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = expected_elems.pop_front();
          if (got.product !== want.product) begin
            $display("%0t: product expected %h, actual %h", $time, want.product, got.product);
            mismatch_count++;
          end
          if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b, actual %b",
                     $time, want.saturated, got.saturated);
            mismatch_count++;
          end
          if (got.bad_index !== want.bad_index) begin
            $display("%0t: bad_index expected %b, actual %b",
                     $time, want.bad_index, got.bad_index);
            mismatch_count++;
          end
        end
      end
      // A request uses the dimensions in force before a write at the same edge.
      if (s_tvalid && s_tready) begin
        expected_elems.push_back(predict_element(s_tuser, s_tdata[ROW_W-1:0],
                                                 s_tdata[ROW_W+COL_W-1:ROW_W],
                                                 s_tdata[S_TDATA_W-1:ROW_W+COL_W]));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A:    rows_a_q    = cfg_data;
          REG_INNER_DIM: inner_dim_q = cfg_data;
          REG_COLS_B:    cols_b_q    = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_elems.size();
    errors  <= mismatch_count;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the matrix multiply element testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on mme_pkg, mme_checker and the block.
module testbench
  import mme_pkg::*;
();

  // Function code the block does not define; it must leave the stores alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [FUNC_W-1:0]    s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;
  int unsigned          pending;
  int unsigned          errors;

  // Dimensions in force, already clamped, as the stimulus sees them.
  int unsigned dim_rows  = 16;
  int unsigned dim_inner = 16;
  int unsigned dim_cols  = 16;
  // Which store entries hold a written value. The stores come out of reset
  // undefined, so a product read is only issued once every entry it sums over
  // has been written.
  bit [255:0]  a_written = '0;
  bit [255:0]  b_written = '0;
  // Idling controls of the current phase, in percent of cycles.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // Long receiver hold-off: the main process counts up hold_reqs and the
  // receiver process, on seeing it change, counts the stretch down on its own.
  int unsigned hold_reqs  = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned cycles     = 0;

  matrix_multiply_element u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mme_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Runaway guard. The slowest correct run is far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls at the phase rate, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Picks an index below limit, or any index when the dimension is zero.
  function automatic logic [3:0] pick_index(input int unsigned limit);
    if (limit == 0) return 4'($urandom);
    return 4'($urandom_range(limit - 1));
  endfunction

  // Element values: raw random patterns saturate often, small and moderate
  // values keep sums in range, and the extremes of the Q16.16 range.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom_range(0, 524287) - 32'd262144;
      2: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(0, 33554431) - 32'd16777216;
    endcase
    return v;
  endfunction

  // Writes the three dimension registers on consecutive edges. Only called
  // while the block is idle.
  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_INNER_DIM;
    cfg_data  <= inner;
    @(posedge clk);
    cfg_index <= REG_COLS_B;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dim_rows  = (rows > MAX_DIM_DEF) ? MAX_DIM_DEF : rows;
    dim_inner = (inner > MAX_DIM_DEF) ? MAX_DIM_DEF : inner;
    dim_cols  = (cols > MAX_DIM_DEF) ? MAX_DIM_DEF : cols;
  endtask

  // Offers one request and returns at the edge where it is accepted. Valid is
  // left high so that a following request goes out back to back; it is only
  // lowered by an idle cycle or at the end of a phase.
  task automatic send_req(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {value, col, row};
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_WR_A && row < dim_rows && col < dim_inner) a_written[{row, col}] = 1'b1;
    if (func == FUNC_WR_B && row < dim_inner && col < dim_cols) b_written[{row, col}] = 1'b1;
  endtask

  // One random request. Most traffic is in-range writes and product reads;
  // a read whose operands are not all written yet becomes a write of the
  // first missing operand instead, so the stores fill up along the way.
  task automatic random_req();
    logic [FUNC_W-1:0] f;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    int unsigned       pick;
    int unsigned       k;
    bit                operands_ready;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // Noise: any function code, any index, often out of range.
      f = FUNC_W'($urandom_range(3));
      r = ROW_W'($urandom);
      c = COL_W'($urandom);
    end else if (pick < 40) begin
      f = FUNC_WR_A;
      r = pick_index(dim_rows);
      c = pick_index(dim_inner);
    end else if (pick < 65) begin
      f = FUNC_WR_B;
      r = pick_index(dim_inner);
      c = pick_index(dim_cols);
    end else begin
      f = FUNC_RD_C;
      r = pick_index(dim_rows);
      c = pick_index(dim_cols);
    end
    if (f == FUNC_RD_C && r < dim_rows && c < dim_cols) begin
      operands_ready = 1'b1;
      for (k = 0; k < dim_inner && operands_ready; k++) begin
        if (!a_written[{r, 4'(k)}]) begin
          operands_ready = 1'b0;
          f = FUNC_WR_A;
          c = 4'(k);
        end else if (!b_written[{4'(k), c}]) begin
          operands_ready = 1'b0;
          f = FUNC_WR_B;
          r = 4'(k);
        end
      end
    end
    send_req(f, r, c, random_value());
  endtask

  // Drops valid and waits until every expected result has come back. The
  // pending count is a registered output of the checker, so the loop waits
  // for a clock edge before it first reads it.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned idle,
                           input int unsigned stall, input logic [DIM_W-1:0] rows,
                           input logic [DIM_W-1:0] inner, input logic [DIM_W-1:0] cols,
                           input bit long_hold);
    idle_pct  = idle;
    stall_pct = stall;
    set_dims(rows, inner, cols);
    if (long_hold) hold_reqs++;
    repeat (count) random_req();
    finish_phase();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on 2 x 2 matrices.
    set_dims(5'd2, 5'd2, 5'd2);
    // Full scale operands: product (0,0) saturates high, (1,0) low, and (0,1) cancels to zero.
    send_req(FUNC_WR_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_req(FUNC_WR_A, 4'd0, 4'd1, 32'h7FFF_FFFF);
    send_req(FUNC_WR_A, 4'd1, 4'd0, 32'h8000_0000);
    send_req(FUNC_WR_A, 4'd1, 4'd1, 32'h8000_0000);
    send_req(FUNC_WR_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_req(FUNC_WR_B, 4'd1, 4'd0, 32'h7FFF_FFFF);
    send_req(FUNC_WR_B, 4'd0, 4'd1, 32'h0001_0000);
    send_req(FUNC_WR_B, 4'd1, 4'd1, 32'hFFFF_0000);
    send_req(FUNC_RD_C, 4'd0, 4'd0, 32'h0000_0000);
    send_req(FUNC_RD_C, 4'd1, 4'd0, 32'hFFFF_FFFF);
    send_req(FUNC_RD_C, 4'd0, 4'd1, 32'h0000_0000);
    // A sum of minus one raw unit must floor to minus one, not round to zero.
    send_req(FUNC_WR_A, 4'd1, 4'd0, 32'h0000_0000);
    send_req(FUNC_WR_A, 4'd1, 4'd1, 32'hFFFF_FFFF);
    send_req(FUNC_WR_B, 4'd1, 4'd1, 32'h0000_0001);
    send_req(FUNC_RD_C, 4'd1, 4'd1, 32'h0000_0000);
    // Out-of-range indices on every function, then the unused code.
    send_req(FUNC_WR_A, 4'd2, 4'd0, 32'h1234_5678);
    send_req(FUNC_WR_A, 4'd0, 4'd15, 32'hFFFF_FFFF);
    send_req(FUNC_WR_B, 4'd15, 4'd15, 32'h8000_0000);
    send_req(FUNC_RD_C, 4'd0, 4'd2, 32'h0000_0000);
    send_req(FUNC_RD_C, 4'd15, 4'd0, 32'h0000_0000);
    send_req(FUNC_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_req(FUNC_UNUSED, 4'd0, 4'd0, 32'h0000_0000);
    // The unused code must not have disturbed this product.
    send_req(FUNC_RD_C, 4'd1, 4'd1, 32'h0000_0000);
    finish_phase();

    // Random phases: full size, oversized registers, unit size with a long
    // receiver hold-off, zero inner dimension, and a rectangular shape.
    run_phase(110, 0, 0, 5'd16, 5'd16, 5'd16, 1'b0);
    run_phase(110, 51, 0, 5'd31, 5'd31, 5'd31, 1'b0);
    run_phase(110, 0, 51, 5'd1, 5'd1, 5'd1, 1'b1);
    run_phase(60, 28, 28, 5'd5, 5'd0, 5'd7, 1'b0);
    run_phase(160, 28, 28, 5'd3, 5'd9, 5'd12, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mme_pkg.sv
hdl/mme_ram.sv
hdl/matrix_multiply_element.sv
sim/mme_checker.sv
sim/testbench.sv
